/* sv/oale_pkg.sv */
// Package for the ordered array list engine.
// Holds sizing constants, command codes and the transaction and internal port types.
// No dependencies.
package oale_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 8;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int VAL_W    = 32;

    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;
    localparam logic [1:0] CMD_SEARCH = 2'd3;

    typedef struct packed {
        logic [1:0]         command;
        logic [POS_W-1:0]   position;
        logic signed [31:0] value;
    } t_in;

    typedef struct packed {
        logic       success;
        logic [3:0] found_index;
        logic [4:0] entry_count;
    } t_out;

    typedef struct packed {
        logic             valid;
        t_out             data;
    } t_res;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [VAL_W-1:0] wdata;
        logic [IDX_W-1:0] raddr;
    } t_mem_req;

endpackage

/* sv/ordered_array_list_engine_top.sv */
// Append writes at the end of the list; insert shifts the entries at and above position up
// one place before writing; remove shifts the entries above position down; search compares
// from index 0 upward. One transaction at a time; the next is taken in the cycle after the
// result leaves the sequencer. Each shift or compare step is a memory read, then its use.
// Reset (i_rst_n, synchronous, active low) empties the list; entries are not cleared.
module ordered_array_list_engine_top import oale_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    t_res             res;
    logic             res_ready;
    t_mem_req         mem_req;
    logic [VAL_W-1:0] rdata;
    logic             r_out_valid;
    t_out             r_out_data;

    oale_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_res       (res),
        .i_res_ready (res_ready),
        .o_mem       (mem_req),
        .i_rdata     (rdata)
    );

    oale_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (rdata)
    );

    assign res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res.valid;
        end
        if (res_ready && res.valid) begin
            r_out_data <= res.data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

/* sv/oale_mem.sv */
// Entry storage: one write port, one read port with registered read data.
// Depends on oale_pkg.
module oale_mem import oale_pkg::*; (
    input  logic             i_clk,
    input  t_mem_req         i_req,
    output logic [VAL_W-1:0] o_rdata
);

    logic [VAL_W-1:0] r_mem [CAPACITY];
    logic [VAL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/oale_ctrl.sv */
// Command sequencer: steps one entry at a time for shift and search (read in S_HEAD, use in S_STEP).
// Depends on oale_pkg; drives oale_mem.
module oale_ctrl import oale_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in              i_in_data,
    output t_res             o_res,
    input  logic             i_res_ready,
    output t_mem_req         o_mem,
    input  logic [VAL_W-1:0] i_rdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_HEAD,
        S_STEP,
        S_DONE
    } t_state;

    t_state             r_state, n_state;
    logic [1:0]         r_cmd, n_cmd;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [VAL_W-1:0]   r_val, n_val;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_idx, n_idx;
    t_out               r_out, n_out;

    logic [CMP_W-1:0]   pos_x, cnt_x, idx_x;
    logic [CNT_W:0]     idx_p1;
    logic               full;

    assign pos_x  = CMP_W'(r_pos);
    assign cnt_x  = CMP_W'(r_count);
    assign idx_x  = CMP_W'(r_idx);
    assign idx_p1 = {1'b0, r_idx} + (CNT_W+1)'(1);
    assign full   = (r_count >= CNT_W'(CAPACITY));

    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_pos   = r_pos;
        n_val   = r_val;
        n_count = r_count;
        n_idx   = r_idx;
        n_out   = r_out;
        o_mem.we    = 1'b0;
        o_mem.waddr = r_idx[IDX_W-1:0];
        o_mem.wdata = i_rdata;
        o_mem.raddr = r_idx[IDX_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd   = i_in_data.command;
                    n_pos   = i_in_data.position;
                    n_val   = i_in_data.value;
                    n_state = S_HEAD;
                    case (i_in_data.command)
                        CMD_INSERT: n_idx = r_count;
                        CMD_REMOVE: n_idx = CNT_W'(i_in_data.position);
                        default:    n_idx = '0;
                    endcase
                end
            end
            S_HEAD: begin
                n_out.success     = 1'b0;
                n_out.found_index = '0;
                case (r_cmd)
                    CMD_APPEND, CMD_INSERT: begin
                        if (r_cmd == CMD_INSERT && pos_x < cnt_x) begin
                            if (full) begin
                                n_state = S_DONE;
                            end else if (idx_x > pos_x) begin
                                o_mem.raddr = IDX_W'(r_idx - CNT_W'(1));
                                n_state     = S_STEP;
                            end else begin
                                o_mem.we    = 1'b1;
                                o_mem.waddr = r_pos[IDX_W-1:0];
                                o_mem.wdata = r_val;
                                n_count     = r_count + CNT_W'(1);
                                n_out.success = 1'b1;
                                n_state     = S_DONE;
                            end
                        end else if (full) begin
                            n_state = S_DONE;
                        end else begin
                            o_mem.we      = 1'b1;
                            o_mem.waddr   = r_count[IDX_W-1:0];
                            o_mem.wdata   = r_val;
                            n_count       = r_count + CNT_W'(1);
                            n_out.success = 1'b1;
                            n_state       = S_DONE;
                        end
                    end
                    CMD_REMOVE: begin
                        if (pos_x >= cnt_x) begin
                            n_state = S_DONE;
                        end else if (idx_p1 < {1'b0, r_count}) begin
                            o_mem.raddr = idx_p1[IDX_W-1:0];
                            n_state     = S_STEP;
                        end else begin
                            n_count       = r_count - CNT_W'(1);
                            n_out.success = 1'b1;
                            n_state       = S_DONE;
                        end
                    end
                    default: begin
                        if (r_idx < r_count) begin
                            o_mem.raddr = r_idx[IDX_W-1:0];
                            n_state     = S_STEP;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                endcase
                n_out.entry_count = 5'(n_count);
            end
            S_STEP: begin
                n_state = S_HEAD;
                case (r_cmd)
                    CMD_INSERT: begin
                        o_mem.we = 1'b1;
                        n_idx    = r_idx - CNT_W'(1);
                    end
                    CMD_REMOVE: begin
                        o_mem.we = 1'b1;
                        n_idx    = idx_p1[CNT_W-1:0];
                    end
                    default: begin
                        if (i_rdata == r_val) begin
                            n_out.success     = 1'b1;
                            n_out.found_index = 4'(r_idx);
                            n_out.entry_count = 5'(r_count);
                            n_state           = S_DONE;
                        end else begin
                            n_idx = idx_p1[CNT_W-1:0];
                        end
                    end
                endcase
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_cmd <= n_cmd;
        r_pos <= n_pos;
        r_val <= n_val;
        r_idx <= n_idx;
        r_out <= n_out;
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_res.valid = (r_state == S_DONE);
    assign o_res.data  = r_out;

endmodule
